// File: sv/keyboard_scancode_encoder_macros.svh
// Assertion macros shared by the keyboard scan code encoder RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef KEYBOARD_SCANCODE_ENCODER_MACROS_SVH
`define KEYBOARD_SCANCODE_ENCODER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define KSE_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KSE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/kse_pkg.sv
// Types and constants of the keyboard scan code encoder.
// No dependencies; used by kse_key_mem, kse_decode and the top level.
package kse_pkg;

  // Input op codes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_FUNC = 1'b1;

  // Configuration register indexes
  localparam logic [7:0] CFG_REPEAT = 8'd0;
  localparam logic [7:0] CFG_CAPS   = 8'd1;
  localparam logic [7:0] CFG_JAPAN  = 8'd2;
  localparam logic [7:0] CFG_EUC    = 8'd3;

  // Entry flag bit positions
  localparam int FL_N     = 0;
  localparam int FL_S     = 1;
  localparam int FL_C     = 2;
  localparam int FL_A     = 3;
  localparam int FL_G     = 4;
  localparam int FL_K     = 5;
  localparam int FL_J     = 6;
  localparam int FL_CAPL  = 7;
  localparam int FL_PUSH  = 8;
  localparam int FL_SW    = 9;
  localparam int FL_AFUNC = 10;
  localparam int FL_PFUNC = 11;
  localparam int FL_NOREP = 12;

  // Modifier status bit positions
  localparam int MS_CTRL  = 0;
  localparam int MS_RSH   = 1;
  localparam int MS_LSH   = 2;
  localparam int MS_ALT   = 3;
  localparam int MS_CAPS  = 4;
  localparam int MS_KANA  = 5;
  localparam int MS_ALTGR = 6;

  // Modifier selectors carried in plain_code of shift-type keys
  localparam logic [7:0] SEL_CTRL    = 8'd0;
  localparam logic [7:0] SEL_RSHIFT  = 8'd1;
  localparam logic [7:0] SEL_LSHIFT  = 8'd2;
  localparam logic [7:0] SEL_ALT     = 8'd3;
  localparam logic [7:0] SEL_CAPS    = 8'd4;
  localparam logic [7:0] SEL_KANAOFF = 8'd5;
  localparam logic [7:0] SEL_KANAON  = 8'd6;
  localparam logic [7:0] SEL_ALTGR   = 8'd7;

  // Lock styles
  localparam logic [1:0] LS_CAPS   = 2'd0;
  localparam logic [1:0] LS_SHIFT  = 2'd1;
  localparam logic [1:0] LS_SHIFT2 = 2'd2;

  // Code selectors
  localparam logic [2:0] CI_NORM  = 3'd0;
  localparam logic [2:0] CI_SHFT  = 3'd1;
  localparam logic [2:0] CI_CTRL  = 3'd2;
  localparam logic [2:0] CI_ALT   = 3'd3;
  localparam logic [2:0] CI_KANA  = 3'd4;
  localparam logic [2:0] CI_KSHFT = 3'd5;

  localparam logic [7:0] SS2_BYTE = 8'h8e;
  localparam logic [7:0] KANA_LO  = 8'ha1;
  localparam logic [7:0] KANA_HI  = 8'hdf;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EMIT
  } state_t;

  // One key table entry plus its pressed bit
  typedef struct packed {
    logic        pressed;
    logic [12:0] flags;
    logic [7:0]  normal;
    logic [7:0]  shifted;
    logic [7:0]  control;
    logic [7:0]  alternate;
    logic [7:0]  kana;
    logic [7:0]  kana_shifted;
  } entry_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       shift_held;
  } result_t;

  // Decode outcome handed back to the control
  typedef struct packed {
    logic       pressed;
    logic [6:0] mods;
    logic [1:0] lock;
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } decision_t;

endpackage

// File: sv/kse_if.sv
// Valid/ready channel interfaces of the keyboard scan code encoder.
// No dependencies; field widths fixed by the block's item formats.
interface kse_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  key_code;
  logic [12:0] entry_flags;
  logic [7:0]  plain_code;
  logic [7:0]  shifted_code;
  logic [7:0]  control_code;
  logic [7:0]  alternate_code;
  logic [7:0]  kana_code_in;
  logic [7:0]  kana_shifted_code;

  modport source (
    output valid, op, key_code, entry_flags, plain_code, shifted_code,
           control_code, alternate_code, kana_code_in, kana_shifted_code,
    input  ready
  );
  modport sink (
    input  valid, op, key_code, entry_flags, plain_code, shifted_code,
           control_code, alternate_code, kana_code_in, kana_shifted_code,
    output ready
  );
endinterface

interface kse_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       shift_held;
  logic       last;

  modport source (output valid, out_kind, out_byte, shift_held, last, input ready);
  modport sink (input valid, out_kind, out_byte, shift_held, last, output ready);
endinterface

interface kse_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/kse_key_mem.sv
// Key table memory: one entry per key, synchronous (registered) read.
// Depends on kse_pkg (entry_t). Per-entry valid bits make unwritten keys read zero.
module kse_key_mem
  import kse_pkg::*;
#(
  parameter int KEY_COUNT = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [$clog2(KEY_COUNT)-1:0] wr_addr,
  input  entry_t                       wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(KEY_COUNT)-1:0] rd_addr,
  output entry_t                       rd_data
);

  entry_t               mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] valid_r;
  entry_t               rd_q_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // never-written entries read as the cleared table
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// File: sv/kse_decode.sv
// Key event decode: repeat check, modifier update and code choice.
// Depends on kse_pkg. Purely combinational; acts on the entry just read.
module kse_decode
  import kse_pkg::*;
(
  input  entry_t    entry,
  input  logic [7:0] key_code,
  input  logic [6:0] mods,
  input  logic [1:0] lock,
  input  logic       repeat_en,
  input  logic [1:0] caps_style,
  input  logic       japanese,
  input  logic       euc,
  output decision_t  dec
);

  typedef struct packed {
    logic       ok;
    logic [2:0] ci;
  } pick_t;

  function automatic pick_t pick_plain(input logic [12:0] f, input logic [6:0] m,
                                       input logic [1:0] ls);
    pick_t p;
    logic  sh;
    p  = '0;
    sh = m[MS_RSH] | m[MS_LSH];
    if (m[MS_CAPS] && sh && f[FL_S]) begin
      if (f[FL_CAPL]) begin
        case (ls)
          LS_CAPS:           p = '{1'b1, CI_SHFT};
          LS_SHIFT, LS_SHIFT2: p = '{1'b1, CI_NORM};
          default:           p = '0;
        endcase
      end else begin
        case (ls)
          LS_CAPS, LS_SHIFT: p = '{1'b1, CI_SHFT};
          LS_SHIFT2:         p = '{1'b1, CI_NORM};
          default:           p = '0;
        endcase
      end
    end else if (m[MS_CAPS] && f[FL_N]) begin
      if (f[FL_CAPL]) begin
        p = '{1'b1, CI_SHFT};
      end else begin
        case (ls)
          LS_CAPS, LS_SHIFT: p = '{1'b1, CI_NORM};
          LS_SHIFT2:         p = '{1'b1, CI_SHFT};
          default:           p = '0;
        endcase
      end
    end else if (sh) begin
      p = '{f[FL_S], CI_SHFT};
    end else begin
      p = '{f[FL_N], CI_NORM};
    end
    return p;
  endfunction

  function automatic logic [7:0] code_at(input entry_t e, input logic [2:0] ci);
    logic [7:0] c;
    case (ci)
      CI_NORM:  c = e.normal;
      CI_SHFT:  c = e.shifted;
      CI_CTRL:  c = e.control;
      CI_ALT:   c = e.alternate;
      CI_KANA:  c = e.kana;
      CI_KSHFT: c = e.kana_shifted;
      default:  c = 8'h00;
    endcase
    return c;
  endfunction

  logic        release_key;
  logic        push;
  logic        sh;
  logic        suppress;
  logic        kana_path;
  logic [12:0] f;
  pick_t       pk;
  logic [7:0]  chosen;

  assign f           = entry.flags;
  assign release_key = key_code[7];
  assign push        = ~release_key;
  assign sh          = mods[MS_RSH] | mods[MS_LSH];
  assign suppress    = push & entry.pressed & (~repeat_en | f[FL_NOREP]);

  always_comb begin
    dec       = '0;
    dec.mods  = mods;
    dec.lock  = lock;
    dec.pressed = push;
    kana_path = 1'b0;
    pk        = '0;
    chosen    = 8'h00;

    if (suppress) begin
      dec.pressed = 1'b1;
    end else if (f[FL_PUSH] | f[FL_SW]) begin
      case (entry.normal)
        SEL_CTRL:    dec.mods[MS_CTRL] = push;
        SEL_RSHIFT:  dec.mods[MS_RSH] = push;
        SEL_LSHIFT:  dec.mods[MS_LSH] = push;
        SEL_ALT:     dec.mods[MS_ALT] = push;
        SEL_CAPS: begin
          if (push) begin
            dec.mods[MS_CAPS] = ~mods[MS_CAPS];
            dec.lock          = caps_style;
          end
        end
        SEL_KANAOFF: begin
          if (push) dec.mods[MS_KANA] = 1'b0;
        end
        SEL_KANAON: begin
          if (push && japanese) dec.mods[MS_KANA] = 1'b1;
        end
        SEL_ALTGR:   dec.mods[MS_ALTGR] = push;
        default:     dec.mods = mods;
      endcase
    end else if ((f[FL_AFUNC] & mods[MS_ALT]) | f[FL_PFUNC]) begin
      if (push) begin
        dec.count = 2'd1;
        dec.res0  = '{KIND_FUNC, key_code, sh};
      end
    end else if (push) begin
      // precedence: alt, ctrl, altgr, kana, then caps/shift
      if (mods[MS_ALT]) begin
        pk = '{f[FL_A], CI_ALT};
      end else if (mods[MS_CTRL]) begin
        pk = '{f[FL_C], CI_CTRL};
      end else if (mods[MS_ALTGR]) begin
        pk = '{f[FL_G], CI_KANA};
      end else if (mods[MS_KANA]) begin
        kana_path = 1'b1;
        if (sh) begin
          pk = '{f[FL_J], CI_KSHFT};
        end else begin
          pk = '{f[FL_K], CI_KANA};
        end
      end else begin
        pk = pick_plain(f, mods, lock);
      end
      chosen = code_at(entry, pk.ci);
      if (pk.ok) begin
        if (kana_path && euc && (chosen inside {[KANA_LO:KANA_HI]})) begin
          dec.count = 2'd2;
          dec.res0  = '{KIND_CHAR, SS2_BYTE, 1'b0};
          dec.res1  = '{KIND_CHAR, chosen, 1'b0};
        end else begin
          dec.count = 2'd1;
          dec.res0  = '{KIND_CHAR, chosen, 1'b0};
        end
      end
    end
  end

endmodule

// File: sv/keyboard_scancode_encoder.sv
// Keyboard scan code encoder top level: control, config registers, result beats.
// Depends on kse_pkg, kse_if, kse_key_mem, kse_decode and the assertion macros.
//
//   channel | dir | beat carries                                  | accepted when
//   in_ch   | in  | op, key_code, entry_flags, six key codes       | valid & ready
//   out_ch  | out | out_kind, out_byte, shift_held, last           | valid & ready
//   cfg_ch  | in  | index, data (register write)                   | valid & ready
//
// Steps: a table load is written at the accepting edge. A key event is accepted
//   with the table read registered, then decoded and written back in ST_LOOK,
//   then emits 0 to 2 result beats in ST_EMIT; the registered key table read
//   is why decode waits for ST_LOOK.
// One item at a time: in_ch.ready is high only while no item is in flight.
// Reset (rst_n low, synchronous) marks every table entry empty and clears
//   modifiers, lock style and config to their defaults; no clearing pass.
// A stalled out_ch holds the current beat; cfg_ch is always ready.
`include "keyboard_scancode_encoder_macros.svh"

module keyboard_scancode_encoder
  import kse_pkg::*;
#(
  parameter int KEY_COUNT = 128
) (
  input logic    clk,
  input logic    rst_n,
  kse_in_if.sink   in_ch,
  kse_out_if.source out_ch,
  kse_cfg_if.sink  cfg_ch
);

  localparam int         AW      = $clog2(KEY_COUNT);
  localparam logic [7:0] KEY_LIM = 8'(KEY_COUNT);

  state_t     state_r, state_nxt;

  // configuration registers
  logic       repeat_en_r;
  logic [1:0] caps_style_r;
  logic       japanese_r;
  logic       euc_r;

  // keyboard state outside the table
  logic [6:0] mods_r;
  logic [1:0] lock_r;

  // item held during lookup, results held during emit
  logic [7:0] key_r;
  result_t    res0_r;
  result_t    res1_r;
  logic [1:0] res_cnt_r;
  logic       res_idx_r;

  logic       in_fire;
  logic       out_fire;
  logic       in_range;
  logic       load_go;
  logic       event_go;
  logic       mem_wr;
  logic [AW-1:0] mem_wr_addr;
  entry_t     mem_wr_data;
  entry_t     mem_rd_data;
  entry_t     load_entry;
  entry_t     wb_entry;
  decision_t  dec;
  result_t    cur;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_fire = out_ch.valid & out_ch.ready;
  // key address is bits 6..0; anything at or past the table size is dropped
  assign in_range = {1'b0, in_ch.key_code[6:0]} < KEY_LIM;
  assign load_go  = in_fire & (in_ch.op == OP_LOAD) & in_range;
  assign event_go = in_fire & (in_ch.op == OP_KEY) & in_range;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_en_r  <= 1'b1;
      caps_style_r <= LS_CAPS;
      japanese_r   <= 1'b0;
      euc_r        <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_REPEAT: repeat_en_r  <= cfg_ch.data[0];
        CFG_CAPS:   caps_style_r <= cfg_ch.data[1:0];
        CFG_JAPAN:  japanese_r   <= cfg_ch.data[0];
        CFG_EUC:    euc_r        <= cfg_ch.data[0];
        default:    ;
      endcase
    end
  end

  // A load writes the whole entry and clears its pressed bit.
  always_comb begin
    load_entry              = '0;
    load_entry.flags        = in_ch.entry_flags;
    load_entry.normal       = in_ch.plain_code;
    load_entry.shifted      = in_ch.shifted_code;
    load_entry.control      = in_ch.control_code;
    load_entry.alternate    = in_ch.alternate_code;
    load_entry.kana         = in_ch.kana_code_in;
    load_entry.kana_shifted = in_ch.kana_shifted_code;
  end

  // Write-back after a key event only touches the pressed bit.
  always_comb begin
    wb_entry         = mem_rd_data;
    wb_entry.pressed = dec.pressed;
  end

  kse_key_mem #(
    .KEY_COUNT (KEY_COUNT)
  ) u_key_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (event_go),
    .rd_addr (in_ch.key_code[AW-1:0]),
    .rd_data (mem_rd_data)
  );

  kse_decode u_decode (
    .entry      (mem_rd_data),
    .key_code   (key_r),
    .mods       (mods_r),
    .lock       (lock_r),
    .repeat_en  (repeat_en_r),
    .caps_style (caps_style_r),
    .japanese   (japanese_r),
    .euc        (euc_r),
    .dec        (dec)
  );

  // Current result beat; idx 1 only exists when two results are held.
  assign cur               = res_idx_r ? res1_r : res0_r;
  assign out_ch.out_kind   = cur.kind;
  assign out_ch.out_byte   = cur.value;
  assign out_ch.shift_held = cur.shift_held;
  assign out_ch.last       = (res_cnt_r == 2'd1) | res_idx_r;

  // Only one item in flight, so a read and the write-back of the same key
  // never overlap: the write lands before the next item can be accepted.
  always_comb begin
    state_nxt    = state_r;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    mem_wr       = 1'b0;
    mem_wr_addr  = in_ch.key_code[AW-1:0];
    mem_wr_data  = load_entry;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        mem_wr      = load_go;
        if (event_go) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        mem_wr      = 1'b1;
        mem_wr_addr = key_r[AW-1:0];
        mem_wr_data = wb_entry;
        state_nxt   = (dec.count == 2'd0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready && out_ch.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r    <= '0;
      lock_r    <= LS_CAPS;
      res_cnt_r <= 2'd0;
      res_idx_r <= 1'b0;
    end else begin
      if (state_r == ST_LOOK) begin
        mods_r    <= dec.mods;
        lock_r    <= dec.lock;
        res_cnt_r <= dec.count;
        res_idx_r <= 1'b0;
      end else if (out_fire && !out_ch.last) begin
        res_idx_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (event_go) begin
      key_r <= in_ch.key_code;
    end
    if (state_r == ST_LOOK) begin
      res0_r <= dec.res0;
      res1_r <= dec.res1;
    end
  end

  `KSE_ASSERT_SAME(a_beat_in_count, out_ch.valid, (res_idx_r < res_cnt_r), "beat past result count")
  `KSE_ASSERT_SAME(a_pair_is_ss2, out_ch.valid && res_cnt_r == 2'd2, res0_r.value == SS2_BYTE, "two-beat result without SS2 lead")
  `KSE_ASSERT_SAME(a_no_write_emit, mem_wr, state_r != ST_EMIT, "table write while emitting")
  `KSE_ASSERT_NEXT(a_last_to_idle, out_fire && out_ch.last, state_r == ST_IDLE, "no return to idle after last beat")

endmodule
